>>> src/alsm_pkg.sv
package alsm_pkg;

  // Window depth and offset range
  localparam int PATTERN_MAX = 16;
  localparam int OFFSET_BITS = 16;

  // Pattern register holds at most 16 literal bytes
  localparam int PAT_BYTES = 16;
  localparam int PAT_CAP   = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;
  localparam int LEN_W     = 5;
  localparam int PIDX_W    = 4;
  localparam int IDX_W     = 7;
  localparam int CMP_W     = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
  localparam int FIELD_W   = 16;
  localparam int OUT_W     = 40;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_ANCHOR_START   = 3'd3,
    REG_ANCHOR_END     = 3'd4,
    REG_IGNORE_CASE    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic fold;
  } cell_ctrl_t;

  typedef struct packed {
    logic               too_long;
    logic [FIELD_W-1:0] match_end;
    logic [FIELD_W-1:0] match_start;
    logic               matched;
  } result_t;

  // Fold ASCII upper case to lower case when enabled
  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

>>> src/alsm_cell.sv
module alsm_cell (
  input  logic                clk,
  input  logic                rst,
  input  alsm_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          shift_in,
  input  logic [7:0]          pat_byte,
  input  logic                care,
  output logic [7:0]          win_byte,
  output logic                eq_next,
  output logic                eq_hold
);
  import alsm_pkg::*;

  // Hold one window byte; take the neighbor's byte on a shift
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      win_byte <= 8'd0;
    end else if (ctrl.shift) begin
      win_byte <= shift_in;
    end
  end

  // Compare the byte about to be loaded and the byte held now
  assign eq_next = !care || (fold_byte(shift_in, ctrl.fold) == pat_byte);
  assign eq_hold = !care || (fold_byte(win_byte, ctrl.fold) == pat_byte);

endmodule

>>> src/alsm_skid.sv
module alsm_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  alsm_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output alsm_pkg::result_t out_data
);
  import alsm_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    spare;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Head drives the port, the spare entry catches one more result
  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      out_data <= spare;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      out_data <= push_data;
    end
    if (push && count == 2'd1 && !pop) begin
      spare <= push_data;
    end
  end

endmodule

>>> src/anchored_literal_string_matcher_core.sv
// Anchored literal string matcher.
//
// Configuration: write registers on cfg_* (cfg_index selects pattern_low,
// pattern_high, pattern_length, anchor_start, anchor_end, ignore_case in that
// order). The port is always ready. Write only between strings or while the
// block has nothing in flight.
// Input: one item per s_tvalid/s_tready handshake. s_tlast low carries one
// text byte in s_tdata; s_tlast high closes the string. s_tuser carries the
// line-start flag, sampled on the first item of each string.
// Output: one result item per end-of-string item, on m_*, from the registered
// head of the output stage. Text bytes give no result.
// Throughput: one item per clock while s_tready is high. Each byte shifts through a row of
// PATTERN_MAX window cells; every cell compares its byte against the pattern
// byte aligned to it, so the match decision is ready in the same cycle.
// Stall: results queue in a two-entry output stage; s_tready drops only when
// both entries hold results that m_tready has not taken.
// Reset: rst clears configuration, window and string state, and drops any
// pending results.
module anchored_literal_string_matcher_core (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // func: end of string
  input  logic        s_tuser,   // [0] bol_flag
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [0] matched, [16:1] match_start,
                                 // [32:17] match_end, [33] too_long, rest zero
);
  import alsm_pkg::*;

  // Configuration registers
  logic [63:0]      pattern_low;
  logic [63:0]      pattern_high;
  logic [LEN_W-1:0] pattern_length;
  logic             anchor_start;
  logic             anchor_end;
  logic             ignore_case;

  // String state
  logic [OFFSET_BITS-1:0] position;
  logic                   found;
  logic [OFFSET_BITS-1:0] found_start;
  logic                   line_start_seen;
  logic                   string_open;
  logic                   overflow;

  logic acc, byte_acc, eos_acc, queue_full;

  assign cfg_ready = 1'b1;
  assign s_tready  = !queue_full;
  assign acc       = s_tvalid && s_tready;
  assign byte_acc  = acc && !s_tlast;
  assign eos_acc   = acc && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      anchor_start   <= 1'b0;
      anchor_end     <= 1'b0;
      ignore_case    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        REG_ANCHOR_START:   anchor_start   <= cfg_data[0];
        REG_ANCHOR_END:     anchor_end     <= cfg_data[0];
        REG_IGNORE_CASE:    ignore_case    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the length to what the window and pattern register hold
  logic [LEN_W-1:0] len_eff;
  assign len_eff = (pattern_length > LEN_W'(PAT_CAP)) ? LEN_W'(PAT_CAP) : pattern_length;

  logic [PAT_BYTES-1:0][7:0] pat_bytes;
  assign pat_bytes = {pattern_high, pattern_low};

  // Row of window cells; cell 0 holds the newest byte
  cell_ctrl_t                  cell_ctrl;
  logic [PATTERN_MAX-1:0][7:0] win;
  logic [PATTERN_MAX-1:0][7:0] shift_in;
  logic [PATTERN_MAX-1:0][7:0] aligned;
  logic [PATTERN_MAX-1:0]      care;
  logic [PATTERN_MAX-1:0]      eq_next;
  logic [PATTERN_MAX-1:0]      eq_hold;

  assign cell_ctrl.shift = byte_acc;
  assign cell_ctrl.clear = eos_acc;
  assign cell_ctrl.fold  = ignore_case;

  for (genvar w = 0; w < PATTERN_MAX; w++) begin : g_cell
    logic [PIDX_W-1:0] pidx;

    // Window byte w lines up with pattern byte len-1-w
    assign care[w]    = (IDX_W'(len_eff) > IDX_W'(w));
    assign pidx       = PIDX_W'(len_eff - LEN_W'(w) - LEN_W'(1));
    assign aligned[w] = fold_byte(pat_bytes[pidx], ignore_case);

    if (w == 0) begin : g_head
      assign shift_in[w] = s_tdata;
    end else begin : g_link
      assign shift_in[w] = win[w-1];
    end

    alsm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .shift_in (shift_in[w]),
      .pat_byte (aligned[w]),
      .care     (care[w]),
      .win_byte (win[w]),
      .eq_next  (eq_next[w]),
      .eq_hold  (eq_hold[w])
    );
  end

  logic match_next, match_hold;
  assign match_next = &eq_next;
  assign match_hold = &eq_hold;

  // Line-start flag for this item: sampled on the first item of a string
  logic lss_eff;
  assign lss_eff = string_open ? line_start_seen : s_tuser;

  // Text byte: advance position (saturating) and look for the first match
  logic [OFFSET_BITS-1:0] pos_next;
  logic                   ovf_next;
  logic                   hit;
  logic [OFFSET_BITS-1:0] hit_start;
  logic                   len_reached;

  assign pos_next    = (position == OFFSET_MAX) ? position : position + OFFSET_BITS'(1);
  assign ovf_next    = overflow || (position == OFFSET_MAX);
  assign len_reached = (CMP_W'(pos_next) >= CMP_W'(len_eff));

  always_comb begin
    hit       = 1'b0;
    hit_start = '0;
    if (!found && len_eff != '0 && (ovf_next || len_reached) && match_next) begin
      if (!anchor_start) begin
        hit       = 1'b1;
        hit_start = ovf_next ? OFFSET_MAX
                             : OFFSET_BITS'(CMP_W'(pos_next) - CMP_W'(len_eff));
      end else if (!ovf_next && CMP_W'(pos_next) == CMP_W'(len_eff) && lss_eff) begin
        hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || eos_acc) begin
      position        <= '0;
      found           <= 1'b0;
      found_start     <= '0;
      line_start_seen <= 1'b0;
      string_open     <= 1'b0;
      overflow        <= 1'b0;
    end else if (byte_acc) begin
      string_open <= 1'b1;
      if (!string_open) begin
        line_start_seen <= s_tuser;
      end
      position <= pos_next;
      overflow <= ovf_next;
      if (hit) begin
        found       <= 1'b1;
        found_start <= hit_start;
      end
    end
  end

  // End of string: decide the result from current state and registers
  result_t                res;
  logic [CMP_W-1:0]       end_sum;
  logic [OFFSET_BITS-1:0] rstart;
  logic [OFFSET_BITS-1:0] rend;
  logic                   rmatch;

  assign end_sum = CMP_W'(found_start) + CMP_W'(len_eff);

  always_comb begin
    rmatch = 1'b0;
    rstart = '0;
    rend   = '0;
    if (anchor_end) begin
      if ((overflow || CMP_W'(position) >= CMP_W'(len_eff)) && match_hold) begin
        if (!anchor_start) begin
          rmatch = 1'b1;
          rstart = overflow ? OFFSET_MAX
                            : OFFSET_BITS'(CMP_W'(position) - CMP_W'(len_eff));
          rend   = overflow ? OFFSET_MAX : position;
        end else if (!overflow && CMP_W'(position) == CMP_W'(len_eff) && lss_eff) begin
          rmatch = 1'b1;
          rend   = position;
        end
      end
    end else if (found) begin
      rmatch = 1'b1;
      rstart = found_start;
      rend   = (end_sum > CMP_W'(OFFSET_MAX)) ? OFFSET_MAX : OFFSET_BITS'(end_sum);
    end else if (len_eff == '0 && (!anchor_start || lss_eff)) begin
      rmatch = 1'b1;
    end
  end

  assign res.matched     = rmatch;
  assign res.match_start = FIELD_W'(rstart);
  assign res.match_end   = FIELD_W'(rend);
  assign res.too_long    = overflow;

  // Output stage: head register plus one spare entry
  result_t out_res;

  alsm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (eos_acc),
    .push_data (res),
    .full      (queue_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {(OUT_W - 2 * FIELD_W - 2)'(0), out_res.too_long, out_res.match_end,
                    out_res.match_start, out_res.matched};

`ifndef SYNTHESIS
  a_result_follows_eos: assert property (@(posedge clk) disable iff (rst)
    eos_acc |=> m_tvalid)
    else $error("no result after end of string");

  a_string_cleared: assert property (@(posedge clk) disable iff (rst)
    eos_acc |=> (position == '0 && !found && !string_open && !overflow))
    else $error("string state not cleared after end of string");

  a_overflow_saturates: assert property (@(posedge clk) disable iff (rst)
    overflow |-> position == OFFSET_MAX)
    else $error("overflow set while position below its limit");

  a_found_in_string: assert property (@(posedge clk) disable iff (rst)
    found |-> string_open)
    else $error("match recorded outside an open string");

  a_byte_advances: assert property (@(posedge clk) disable iff (rst)
    byte_acc |=> (string_open && (position == $past(pos_next))))
    else $error("position did not advance on a text byte");
`endif

endmodule
